>>> rtl/int8_matmul_requantize_unit_macros.svh
// assertion macros for the int8 matrix multiply and requantize unit
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef INT8_MATMUL_REQUANTIZE_UNIT_MACROS_SVH
`define INT8_MATMUL_REQUANTIZE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IMRU_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("imru assertion failed");
`define IMRU_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("imru forbidden condition seen");
`else
`define IMRU_ASSERT(label, clk, rstn, prop)
`define IMRU_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

>>> rtl/imru_pkg.sv
// shared types, constants and helpers for the int8 matrix multiply unit
// no dependencies
package imru_pkg;

    localparam int MAX_N_DEF  = 16;
    localparam int MAX_K_DEF  = 64;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [4:0]  N_USED_RST      = 5'd16;
    localparam logic [6:0]  K_USED_RST      = 7'd64;
    localparam logic [31:0] SCALE_MULT_RST  = 32'd1073741824;
    localparam logic [5:0]  SCALE_SHIFT_RST = 6'd30;

    localparam logic signed [7:0] Q_MIN = -8'sd128;
    localparam logic signed [7:0] Q_MAX = 8'sd127;

    typedef struct packed {
        logic              action;
        logic [5:0]        weight_row;
        logic [3:0]        weight_col;
        logic signed [7:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] result_value;
        logic [3:0]        result_col;
        logic              row_last;
    } out_item_t;

    typedef struct packed {
        logic mac_en;
        logic shift_en;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_RUN,
        S_WAIT,
        S_MUL,
        S_RND,
        S_HOLD
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_USED,
        CFG_K_USED,
        CFG_SCALE_MULT,
        CFG_SCALE_SHIFT
    } cfg_index_t;

    localparam logic ACTION_WEIGHT = 1'b0;
    localparam logic ACTION_ACT    = 1'b1;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> rtl/imru_ram.sv
// generic simple dual-port ram with registered read
// depends on imru_pkg
module imru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = imru_pkg::MAX_K_DEF
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [imru_pkg::addr_width(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [imru_pkg::addr_width(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/imru_cell.sv
// one column cell: weight column ram and column accumulator, shifts to neighbour
// depends on imru_pkg and imru_ram
module imru_cell #(
    parameter int DEPTH = imru_pkg::MAX_K_DEF,
    parameter int ACC_W = 22
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  imru_pkg::cell_ctrl_t                   ctrl,
    input  logic                                   wr_en,
    input  logic [imru_pkg::addr_width(DEPTH)-1:0] wr_addr,
    input  logic signed [7:0]                      wr_data,
    input  logic [imru_pkg::addr_width(DEPTH)-1:0] rd_addr,
    input  logic signed [7:0]                      act_value,
    input  logic signed [ACC_W-1:0]                shift_in,
    output logic signed [ACC_W-1:0]                acc
);

    logic [7:0]              w_rd;
    logic signed [15:0]      prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    imru_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (w_rd)
    );

    assign prod = act_value * $signed(w_rd);

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.shift_en) begin
            acc_next = shift_in;
        end else if (ctrl.mac_en) begin
            acc_next = acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/imru_requant.sv
// requantiser: magnitude times scale, round half away from zero, clamp to int8
// depends on imru_pkg
module imru_requant #(
    parameter int ACC_W = 22
) (
    input  logic                    aclk,
    input  logic                    mul_en,
    input  logic signed [ACC_W-1:0] sum,
    input  logic [31:0]             scale_multiplier,
    input  logic [5:0]              scale_shift,
    output logic signed [7:0]       q
);

    localparam int PROD_W = ACC_W + 32;

    logic [ACC_W-1:0]  mag;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [63:0]       half;
    logic [63:0]       rounded;

    assign mag = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            neg_reg  <= sum[ACC_W-1];
            prod_reg <= PROD_W'(mag) * PROD_W'(scale_multiplier);
        end
    end

    always_comb begin
        half    = 64'd0;
        rounded = 64'(prod_reg);
        if (scale_shift != 6'd0) begin
            half    = 64'd1 << (scale_shift - 6'd1);
            rounded = (64'(prod_reg) + half) >> scale_shift;
        end
        if (neg_reg) begin
            q = (rounded > 64'(imru_pkg::Q_MAX)) ? imru_pkg::Q_MIN
                                                 : $signed(8'd0 - rounded[7:0]);
        end else begin
            q = (rounded >= 64'(imru_pkg::Q_MAX)) ? imru_pkg::Q_MAX
                                                  : $signed(rounded[7:0]);
        end
    end

endmodule

>>> rtl/int8_matmul_requantize_unit.sv
// top level of the int8 matrix multiply and requantize unit
// depends on imru_pkg, imru_cell, imru_requant and the macros header
//
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    imru_pkg::in_item_t (weight write or activation)
// m_        out  m_valid/m_ready    imru_pkg::out_item_t (one column result)
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// weight writes and activations are taken one per cycle while a row is open
// the last activation of a row closes the input until every column result of the row
// is taken, m_ready stalls included: sums shift down the cell chain into one shared
// requantiser (multiply, round, hold), one column at a time
// reset clears control, config and accumulators; the weight rams are not cleared
// a stalled result holds in the output register until taken
`include "int8_matmul_requantize_unit_macros.svh"
module int8_matmul_requantize_unit #(
    parameter int MAX_N = imru_pkg::MAX_N_DEF,
    parameter int MAX_K = imru_pkg::MAX_K_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  imru_pkg::in_item_t                s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output imru_pkg::out_item_t               m_payload,
    input  logic                              cfg_we,
    input  logic [imru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imru_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int DEPTH_W = imru_pkg::addr_width(MAX_K);
    localparam int KCNT_W  = $clog2(MAX_K) + 1;
    localparam int CNT_W   = $clog2(MAX_N) + 1;
    localparam int ACC_W   = $clog2(MAX_K) + 16;

    logic [4:0]  n_used_reg;
    logic [6:0]  k_used_reg;
    logic [31:0] scale_mult_reg;
    logic [5:0]  scale_shift_reg;

    imru_pkg::state_t     state_reg, state_next;
    imru_pkg::cell_ctrl_t cell_ctrl;
    imru_pkg::out_item_t  m_payload_reg;

    logic [DEPTH_W-1:0]      dp_reg, dp_next;
    logic [CNT_W-1:0]        col_cnt_reg;
    logic                    act_v_reg;
    logic signed [7:0]       act_value_reg;
    logic [KCNT_W-1:0]       eff_k;
    logic [CNT_W-1:0]        eff_n;
    logic                    s_fire, act_fire, wt_fire, act_last;
    logic                    mul_en, out_load;
    logic [DEPTH_W-1:0]      wr_addr;
    logic [MAX_N-1:0]        cell_we;
    logic signed [ACC_W-1:0] acc_chain [MAX_N];
    logic signed [7:0]       q;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_used_reg      <= imru_pkg::N_USED_RST;
            k_used_reg      <= imru_pkg::K_USED_RST;
            scale_mult_reg  <= imru_pkg::SCALE_MULT_RST;
            scale_shift_reg <= imru_pkg::SCALE_SHIFT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                imru_pkg::CFG_N_USED:      n_used_reg      <= cfg_wdata[4:0];
                imru_pkg::CFG_K_USED:      k_used_reg      <= cfg_wdata[6:0];
                imru_pkg::CFG_SCALE_MULT:  scale_mult_reg  <= cfg_wdata[31:0];
                imru_pkg::CFG_SCALE_SHIFT: scale_shift_reg <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (n_used_reg == 5'd0) begin
            eff_n = CNT_W'(1);
        end else if (32'(n_used_reg) > MAX_N) begin
            eff_n = CNT_W'(MAX_N);
        end else begin
            eff_n = CNT_W'(n_used_reg);
        end
        if (k_used_reg == 7'd0) begin
            eff_k = KCNT_W'(1);
        end else if (32'(k_used_reg) > MAX_K) begin
            eff_k = KCNT_W'(MAX_K);
        end else begin
            eff_k = KCNT_W'(k_used_reg);
        end
    end

    assign s_fire   = s_valid && s_ready;
    assign act_fire = s_fire && (s_payload.action == imru_pkg::ACTION_ACT);
    assign wt_fire  = s_fire && (s_payload.action == imru_pkg::ACTION_WEIGHT)
                      && (32'(s_payload.weight_row) < MAX_K);
    assign act_last = (KCNT_W'(dp_reg) + KCNT_W'(1)) >= eff_k;
    assign wr_addr  = DEPTH_W'(s_payload.weight_row);

    always_comb begin
        dp_next = dp_reg;
        if (act_fire) begin
            dp_next = act_last ? '0 : DEPTH_W'(dp_reg + DEPTH_W'(1));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imru_pkg::S_RUN: begin
                if (act_fire && act_last) begin
                    state_next = imru_pkg::S_WAIT;
                end
            end
            imru_pkg::S_WAIT: state_next = imru_pkg::S_MUL;
            imru_pkg::S_MUL:  state_next = imru_pkg::S_RND;
            imru_pkg::S_RND:  state_next = imru_pkg::S_HOLD;
            imru_pkg::S_HOLD: begin
                if (m_ready) begin
                    state_next = m_payload_reg.row_last ? imru_pkg::S_RUN
                                                        : imru_pkg::S_MUL;
                end
            end
            default: state_next = imru_pkg::S_RUN;
        endcase
    end

    // outputs
    always_comb begin
        s_ready          = 1'b0;
        m_valid          = 1'b0;
        mul_en           = 1'b0;
        out_load         = 1'b0;
        cell_ctrl        = '0;
        cell_ctrl.mac_en = act_v_reg;
        case (state_reg)
            imru_pkg::S_RUN: s_ready = 1'b1;
            imru_pkg::S_MUL: begin
                mul_en             = 1'b1;
                cell_ctrl.shift_en = 1'b1;
            end
            imru_pkg::S_RND: out_load = 1'b1;
            imru_pkg::S_HOLD: begin
                m_valid         = 1'b1;
                cell_ctrl.clear = m_ready && m_payload_reg.row_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imru_pkg::S_RUN;
            dp_reg      <= '0;
            col_cnt_reg <= '0;
            act_v_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            dp_reg    <= dp_next;
            act_v_reg <= act_fire;
            if (cell_ctrl.clear) begin
                col_cnt_reg <= '0;
            end else if (mul_en) begin
                col_cnt_reg <= CNT_W'(col_cnt_reg + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (act_fire) begin
            act_value_reg <= s_payload.value;
        end
        if (out_load) begin
            m_payload_reg.result_value <= q;
            m_payload_reg.result_col   <= 4'(col_cnt_reg - CNT_W'(1));
            m_payload_reg.row_last     <= (col_cnt_reg == eff_n);
        end
    end

    for (genvar j = 0; j < MAX_N; j++) begin : g_cell
        logic signed [ACC_W-1:0] shift_src;
        if (j == MAX_N - 1) begin : g_end
            assign shift_src = '0;
        end else begin : g_mid
            assign shift_src = acc_chain[j+1];
        end
        assign cell_we[j] = wt_fire && (32'(s_payload.weight_col) == j);
        imru_cell #(
            .DEPTH (MAX_K),
            .ACC_W (ACC_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .wr_en     (cell_we[j]),
            .wr_addr   (wr_addr),
            .wr_data   (s_payload.value),
            .rd_addr   (dp_reg),
            .act_value (act_value_reg),
            .shift_in  (shift_src),
            .acc       (acc_chain[j])
        );
    end

    imru_requant #(
        .ACC_W (ACC_W)
    ) u_requant (
        .aclk             (aclk),
        .mul_en           (mul_en),
        .sum              (acc_chain[0]),
        .scale_multiplier (scale_mult_reg),
        .scale_shift      (scale_shift_reg),
        .q                (q)
    );

    assign m_payload = m_payload_reg;

    `IMRU_ASSERT(a_last_act_closes_row, aclk, aresetn,
        (act_fire && act_last) |=> (state_reg == imru_pkg::S_WAIT))
    `IMRU_ASSERT(a_row_end_reopens, aclk, aresetn,
        (m_valid && m_ready && m_payload.row_last)
        |=> (state_reg == imru_pkg::S_RUN && dp_reg == '0 && col_cnt_reg == '0))
    `IMRU_ASSERT(a_mac_only_open_row, aclk, aresetn,
        act_v_reg |-> (state_reg == imru_pkg::S_RUN || state_reg == imru_pkg::S_WAIT))
    `IMRU_ASSERT(a_result_from_round, aclk, aresetn,
        $rose(m_valid) |-> ($past(state_reg) == imru_pkg::S_RND))
    `IMRU_ASSERT_NEVER(a_col_overrun, aclk, aresetn, col_cnt_reg > eff_n)

endmodule

>>> sim/int8_matmul_requantize_unit_tb.sv
// testbench for int8_matmul_requantize_unit: directed and random requests checked against
// a local matrix multiply and requantise predictor, with random sender gaps and output stalls
// depends on imru_pkg and the rtl of int8_matmul_requantize_unit
module int8_matmul_requantize_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_N       = imru_pkg::MAX_N_DEF;
    localparam int MAX_K       = imru_pkg::MAX_K_DEF;
    localparam int IDLE_WAIT   = 3 * MAX_N + 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_mode_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    imru_pkg::in_item_t              s_payload;
    logic                            m_valid;
    logic                            m_ready;
    imru_pkg::out_item_t             m_payload;
    logic                            cfg_we;
    logic [imru_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [imru_pkg::CFG_DATA_W-1:0] cfg_wdata;

    logic signed [7:0] weight_model [MAX_K][MAX_N];
    longint            column_acc [MAX_N];
    int                depth_count;
    logic [4:0]        n_reg;
    logic [6:0]        k_reg;
    logic [31:0]       mult_reg;
    logic [5:0]        shift_reg;

    imru_pkg::out_item_t expected_results [$];
    int        mismatch_count  = 0;
    int        cycle_count     = 0;
    int        hold_off_request = 0;

    int8_matmul_requantize_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic signed [7:0] requantise(input longint acc);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] scaled;
        logic [64:0] rounded;
        neg  = acc < 0;
        mag  = neg ? 64'(-acc) : 64'(acc);
        prod = mag * {32'd0, mult_reg};
        if (shift_reg == 6'd0) begin
            scaled = prod;
        end else begin
            rounded = {1'b0, prod} + (65'd1 << (shift_reg - 6'd1));
            scaled  = rounded[64] ? 64'hFFFF_FFFF : (rounded[63:0] >> shift_reg);
        end
        if (neg) begin
            return (scaled >= 64'd128) ? imru_pkg::Q_MIN : -$signed(scaled[7:0]);
        end
        return (scaled >= 64'd127) ? imru_pkg::Q_MAX : $signed(scaled[7:0]);
    endfunction

    function automatic void predict_request(input imru_pkg::in_item_t item);
        int                  k_eff;
        int                  n_eff;
        imru_pkg::out_item_t res;
        if (item.action == imru_pkg::ACTION_WEIGHT) begin
            weight_model[item.weight_row][item.weight_col] = item.value;
            return;
        end
        k_eff = (k_reg == 7'd0) ? 1 : (k_reg > MAX_K) ? MAX_K : int'(k_reg);
        for (int j = 0; j < MAX_N; j++) begin
            column_acc[j] += longint'(item.value)
                             * longint'(weight_model[depth_count % MAX_K][j]);
        end
        if (depth_count + 1 < k_eff) begin
            depth_count++;
            return;
        end
        n_eff = (n_reg == 5'd0) ? 1 : (n_reg > MAX_N) ? MAX_N : int'(n_reg);
        for (int j = 0; j < n_eff; j++) begin
            res.result_value = requantise(column_acc[j]);
            res.result_col   = 4'(j);
            res.row_last     = (j + 1 == n_eff);
            expected_results.push_back(res);
        end
        for (int j = 0; j < MAX_N; j++) begin
            column_acc[j] = 0;
        end
        depth_count = 0;
    endfunction

    function automatic imru_pkg::in_item_t make_request(input logic action,
                                                        input logic [5:0] row,
                                                        input logic [3:0] col,
                                                        input logic [7:0] value);
        imru_pkg::in_item_t item;
        item.action     = action;
        item.weight_row = row;
        item.weight_col = col;
        item.value      = value;
        return item;
    endfunction

    function automatic imru_pkg::in_item_t random_request();
        logic action;
        action = ($urandom_range(0, 99) < 85) ? imru_pkg::ACTION_ACT : imru_pkg::ACTION_WEIGHT;
        return make_request(action, 6'($urandom), 4'($urandom), 8'($urandom));
    endfunction

    task automatic send_request(input imru_pkg::in_item_t item);
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        predict_request(item);
    endtask

    task automatic send_activation(input logic [7:0] value);
        send_request(make_request(imru_pkg::ACTION_ACT, 6'($urandom), 4'($urandom), value));
    endtask

    task automatic send_activations(input int count);
        repeat (count) send_activation(8'($urandom));
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles == 0) return;
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_register(input imru_pkg::cfg_index_t idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            imru_pkg::CFG_N_USED:      n_reg     = data[4:0];
            imru_pkg::CFG_K_USED:      k_reg     = data[6:0];
            imru_pkg::CFG_SCALE_MULT:  mult_reg  = data;
            imru_pkg::CFG_SCALE_SHIFT: shift_reg = data[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [4:0] n, input logic [6:0] k,
                              input logic [31:0] mult, input logic [5:0] shift);
        wait_for_results();
        write_register(imru_pkg::CFG_N_USED, 32'(n));
        write_register(imru_pkg::CFG_K_USED, 32'(k));
        write_register(imru_pkg::CFG_SCALE_MULT, mult);
        write_register(imru_pkg::CFG_SCALE_SHIFT, 32'(shift));
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_weight_load();
        for (int r = 0; r < MAX_K; r++) begin
            for (int c = 0; c < MAX_N; c++) begin
                send_request(make_request(imru_pkg::ACTION_WEIGHT, 6'(r), 4'(c),
                                          8'($urandom)));
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_activations(MAX_K);
    endtask

    task automatic test_scale_extremes();
        logic signed [7:0] row_values [16];
        row_values = '{8'sd127, -8'sd128, 8'sd1, -8'sd1, 8'sd3, -8'sd3, 8'sd0, 8'sd64,
                       -8'sd64, 8'sd2, -8'sd2, 8'sd5, -8'sd5, 8'sd100, -8'sd100, 8'sd127};
        for (int c = 0; c < MAX_N; c++) begin
            send_request(make_request(imru_pkg::ACTION_WEIGHT, 6'd0, 4'(c), row_values[c]));
        end
        set_config(5'd16, 7'd1, 32'hFFFF_FFFF, 6'd0);
        send_activation(8'sd127);
        send_activation(-8'sd128);
        set_config(5'd16, 7'd1, 32'd1, 6'd1);
        send_activation(8'sd1);
        send_activation(-8'sd1);
        set_config(5'd16, 7'd1, 32'd0, 6'd0);
        send_activation(8'sd127);
        set_config(5'd16, 7'd1, 32'hFFFF_FFFF, 6'd63);
        send_activation(-8'sd128);
        set_config(5'd16, 7'd1, 32'h8000_0000, 6'd32);
        send_activation(8'sd127);
        send_activation(-8'sd3);
    endtask

    task automatic test_register_limits();
        set_config(5'd0, 7'd0, 32'd65536, 6'd16);
        send_activations(3);
        set_config(5'd31, 7'd127, 32'd16384, 6'd22);
        send_activations(MAX_K);
        set_config(5'd17, 7'd3, 32'd1 << 20, 6'd24);
        send_activations(6);
        set_config(5'd1, 7'd2, 32'd1 << 20, 6'd24);
        send_activations(4);
    endtask

    task automatic test_depth_lowered();
        set_config(5'd8, 7'd8, 32'd1 << 18, 6'd24);
        send_activations(5);
        set_config(5'd8, 7'd3, 32'd1 << 18, 6'd24);
        send_activations(4);
        set_config(5'd8, 7'd0, 32'd1 << 18, 6'd24);
        send_activations(2);
    endtask

    task automatic test_weight_mid_row();
        set_config(5'd16, 7'd4, 32'd1 << 18, 6'd22);
        send_activations(2);
        send_request(make_request(imru_pkg::ACTION_WEIGHT, 6'd0, 4'd5, 8'($urandom)));
        send_request(make_request(imru_pkg::ACTION_WEIGHT, 6'd2, 4'd9, 8'($urandom)));
        send_activations(2);
    endtask

    task automatic test_output_backpressure();
        set_config(5'd16, 7'd2, 32'd1 << 20, 6'd24);
        hold_off_request = 400;
        send_activations(16);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         phase_left;
        int         burst;
        logic [4:0] n;
        logic [6:0] k;
        logic [31:0] mult;
        logic [5:0] shift;
        sent = 0;
        while (sent < 320) begin
            n = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
            case ($urandom_range(0, 11))
                0:       k = 7'd0;
                1:       k = 7'd64;
                2:       k = 7'd127;
                3:       k = 7'($urandom);
                default: k = 7'($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 7) == 0) begin
                mult  = $urandom;
                shift = 6'($urandom);
            end else begin
                mult  = $urandom_range(1, 1 << 20);
                shift = 6'($urandom_range(16, 34));
            end
            set_config(n, k, mult, shift);
            phase_left = $urandom_range(20, 50);
            while (phase_left > 0) begin
                burst = $urandom_range(1, 10);
                repeat (burst) send_request(random_request());
                phase_left -= burst;
                sent += burst;
                if ($urandom_range(0, 1) == 0) pause_sender($urandom_range(1, 8));
                if ($urandom_range(0, 15) == 0) wait_for_results();
            end
        end
    endtask

    // output ready pattern, with a long hold-off when one is requested
    initial begin
        rx_mode_t mode;
        int       left;
        int       count;
        m_ready = 1'b0;
        mode    = RX_FREE;
        left    = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request != 0) begin
                count = hold_off_request;
                hold_off_request = 0;
                m_ready <= 1'b0;
                repeat (count - 1) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    RX_FREE:      m_ready <= 1'b1;
                    RX_RANDOM:    m_ready <= 1'($urandom);
                    RX_SPARSE:    m_ready <= ($urandom_range(0, 3) == 0);
                    RX_ALTERNATE: m_ready <= ~m_ready;
                    default:      m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        imru_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result value %0d col %0d last %0b", $time,
                         m_payload.result_value, m_payload.result_col, m_payload.row_last);
            end else begin
                want = expected_results.pop_front();
                if (m_payload.result_value !== want.result_value
                        || m_payload.result_col !== want.result_col
                        || m_payload.row_last !== want.row_last) begin
                    mismatch_count++;
                    $display("%0t: expected value %0d col %0d last %0b, %s %0d col %0d last %0b",
                             $time, want.result_value, want.result_col, want.row_last,
                             "actual value", m_payload.result_value, m_payload.result_col,
                             m_payload.row_last);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        n_reg       = imru_pkg::N_USED_RST;
        k_reg       = imru_pkg::K_USED_RST;
        mult_reg    = imru_pkg::SCALE_MULT_RST;
        shift_reg   = imru_pkg::SCALE_SHIFT_RST;
        depth_count = 0;
        for (int j = 0; j < MAX_N; j++) begin
            column_acc[j] = 0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_weight_load();
        test_reset_defaults();
        test_scale_extremes();
        test_register_limits();
        test_depth_lowered();
        test_weight_mid_row();
        test_output_backpressure();
        test_random_traffic();
        wait_for_results();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> int8_matmul_requantize_unit.f
+incdir+rtl
rtl/imru_pkg.sv
rtl/imru_ram.sv
rtl/imru_cell.sv
rtl/imru_requant.sv
rtl/int8_matmul_requantize_unit.sv
sim/int8_matmul_requantize_unit_tb.sv
